FILE: design/ocd_pkg.sv
// Shared types and constants for the output channel calibrate-and-drive block.
package ocd_pkg;

  // Converter range and sweep constants
  localparam logic [11:0] DAC_MAX     = 12'd4095;
  localparam logic [11:0] SWEEP_START = 12'd4000;
  localparam logic [11:0] SWEEP_FLOOR = 12'd2000;
  localparam logic [11:0] SWEEP_STEP  = 12'd10;
  localparam logic [9:0]  POWER_LIMIT = 10'd1000;

  // Configuration port geometry
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers
  localparam logic signed [15:0] PRECHECK_RESET = 16'sd240;
  localparam logic signed [15:0] OK_RESET       = 16'sd0;
  localparam logic signed [15:0] OVER_RESET     = 16'sd32767;
  localparam logic [11:0]        OFF_RESET      = 12'd0;

  typedef enum logic [1:0] {
    ST_UNINIT = 2'd0,
    ST_CAL    = 2'd1,
    ST_READY  = 2'd2,
    ST_FAULT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_POWER  = 2'd2,
    ACT_PULSE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRECHECK = 2'd0,
    CFG_OK       = 2'd1,
    CFG_OVER     = 2'd2,
    CFG_OFF      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    PH_PRECHECK = 1'b0,
    PH_SWEEP    = 1'b1
  } phase_t;

  typedef struct packed {
    logic signed [15:0] precheck_threshold;
    logic signed [15:0] ok_threshold;
    logic signed [15:0] over_threshold;
    logic [11:0]        off_point;
  } cfg_t;

  typedef struct packed {
    action_t            action;
    logic signed [15:0] sample;
    logic [15:0]        power;
    logic [7:0]         pos_width;
    logic [7:0]         neg_width;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        rejected;
    logic        dac_write;
    logic [11:0] drive_level;
    logic        gates_on;
    logic        power_error;
    logic        pulse_valid;
    logic [7:0]  pulse_pos;
    logic [7:0]  pulse_neg;
  } result_t;

endpackage

FILE: design/ocd_if.sv
// Valid/ready channel interfaces for command input and result output.
interface ocd_in_if import ocd_pkg::*;;
  logic               valid;
  logic               ready;
  action_t            action;
  logic signed [15:0] sample;
  logic [15:0]        power;
  logic [7:0]         pos_width;
  logic [7:0]         neg_width;

  modport source (output valid, action, sample, power, pos_width, neg_width, input ready);
  modport sink   (input valid, action, sample, power, pos_width, neg_width, output ready);
endinterface

interface ocd_out_if import ocd_pkg::*;;
  logic        valid;
  logic        ready;
  status_t     status;
  logic        rejected;
  logic        dac_write;
  logic [11:0] drive_level;
  logic        gates_on;
  logic        power_error;
  logic        pulse_valid;
  logic [7:0]  pulse_pos;
  logic [7:0]  pulse_neg;

  modport source (output valid, status, rejected, dac_write, drive_level, gates_on,
                  power_error, pulse_valid, pulse_pos, pulse_neg, input ready);
  modport sink   (input valid, status, rejected, dac_write, drive_level, gates_on,
                  power_error, pulse_valid, pulse_pos, pulse_neg, output ready);
endinterface

FILE: design/ocd_cfg_regs.sv
// Configuration register file: thresholds and power offset.
module ocd_cfg_regs import ocd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Register writes, reset to documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precheck_threshold <= PRECHECK_RESET;
      cfg.ok_threshold       <= OK_RESET;
      cfg.over_threshold     <= OVER_RESET;
      cfg.off_point          <= OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRECHECK: cfg.precheck_threshold <= cfg_data;
        CFG_OK:       cfg.ok_threshold       <= cfg_data;
        CFG_OVER:     cfg.over_threshold     <= cfg_data;
        CFG_OFF:      cfg.off_point          <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/ocd_step.sv
// Channel state registers and the per-command decision logic.
module ocd_step import ocd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  status_t     chan_status, chan_status_next;
  phase_t      cal_phase, cal_phase_next;
  logic [11:0] sweep_level, sweep_level_next;
  logic [11:0] cal_level, cal_level_next;

  // Power mapping: cal + offset - 2*min(power, limit)
  logic [9:0]         pwr_clamped;
  logic [12:0]        pwr_base;
  logic signed [13:0] pwr_mapped;
  logic               pwr_out_of_range;
  logic [11:0]        sweep_dec;

  assign pwr_clamped = (item.power > {6'd0, POWER_LIMIT}) ? POWER_LIMIT : item.power[9:0];
  assign pwr_base    = {1'b0, cal_level} + {1'b0, cfg.off_point};
  assign pwr_mapped  = $signed({1'b0, pwr_base}) - $signed({3'b000, pwr_clamped, 1'b0});
  assign pwr_out_of_range = pwr_mapped < 14'sd0 ||
                            pwr_mapped > $signed({2'b00, DAC_MAX});
  assign sweep_dec   = sweep_level - SWEEP_STEP;

  // Decision logic
  always_comb begin
    chan_status_next = chan_status;
    cal_phase_next   = cal_phase;
    sweep_level_next = sweep_level;
    cal_level_next   = cal_level;
    result           = '0;

    case (item.action)
      ACT_START: begin
        if (chan_status != ST_UNINIT) begin
          result.rejected = 1'b1;
        end else begin
          chan_status_next   = ST_CAL;
          cal_phase_next     = PH_PRECHECK;
          sweep_level_next   = SWEEP_START;
          result.dac_write   = 1'b1;
          result.drive_level = DAC_MAX;
        end
      end
      ACT_SAMPLE: begin
        if (chan_status != ST_CAL) begin
          result.rejected = 1'b1;
        end else if (cal_phase == PH_PRECHECK) begin
          if (item.sample > cfg.precheck_threshold) begin
            // drive already off, no write needed
            chan_status_next = ST_FAULT;
          end else begin
            cal_phase_next     = PH_SWEEP;
            sweep_level_next   = SWEEP_START;
            result.dac_write   = 1'b1;
            result.drive_level = SWEEP_START;
            result.gates_on    = 1'b1;
          end
        end else begin
          if (item.sample > cfg.over_threshold) begin
            chan_status_next   = ST_FAULT;
            result.dac_write   = 1'b1;
            result.drive_level = DAC_MAX;
          end else if (item.sample > cfg.ok_threshold) begin
            cal_level_next     = sweep_level;
            chan_status_next   = ST_READY;
            result.dac_write   = 1'b1;
            result.drive_level = DAC_MAX;
          end else if (sweep_level > SWEEP_FLOOR + SWEEP_STEP) begin
            sweep_level_next   = sweep_dec;
            result.dac_write   = 1'b1;
            result.drive_level = sweep_dec;
            result.gates_on    = 1'b1;
          end else begin
            // sweep exhausted without reaching the ok level
            chan_status_next   = ST_FAULT;
            result.dac_write   = 1'b1;
            result.drive_level = DAC_MAX;
          end
        end
      end
      ACT_POWER: begin
        if (chan_status != ST_READY) begin
          result.rejected = 1'b1;
        end else if (pwr_out_of_range) begin
          result.power_error = 1'b1;
        end else begin
          result.dac_write   = 1'b1;
          result.drive_level = pwr_mapped[11:0];
        end
      end
      ACT_PULSE: begin
        if (chan_status != ST_READY) begin
          result.rejected = 1'b1;
        end else begin
          result.pulse_valid = 1'b1;
          result.pulse_pos   = item.pos_width;
          result.pulse_neg   = item.neg_width;
        end
      end
      default: ;
    endcase

    result.status = chan_status_next;
  end

  // State update when the command moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_status <= ST_UNINIT;
      cal_phase   <= PH_PRECHECK;
      sweep_level <= SWEEP_START;
      cal_level   <= DAC_MAX;
    end else if (advance) begin
      chan_status <= chan_status_next;
      cal_phase   <= cal_phase_next;
      sweep_level <= sweep_level_next;
      cal_level   <= cal_level_next;
    end
  end

endmodule

FILE: design/output_channel_calibrate_and_drive_core.sv
// Top level of the output channel calibrate-and-drive controller.
//
// Commands enter through a registered input stage, are decided by the channel
// logic and land in a result register, so one command is taken every clock
// cycle while the output side keeps up. A command is decided in the input
// register and moves to the result register on the edge that also updates
// the channel state. When the output side stalls, the input register holds
// one more command and then the input stalls. Each command yields exactly one
// result. A start command (only from uninitialized) powers the drive off and
// begins calibration: the first sample is a power-off pre-check, then the
// converter level sweeps down from 4000 in steps of 10 above 2000 with gates
// on, until a sample exceeds the ok threshold (ready) or the over threshold
// or the floor is hit (fault). When ready, power requests are mapped to
// cal + offset - 2*min(power,1000) and pulse requests are forwarded.
// Configuration registers should be written only while the channel is idle.
module output_channel_calibrate_and_drive_core import ocd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ocd_in_if.sink                in_ch,
  ocd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t res_comb;
  result_t res_reg;
  logic    res_valid;
  logic    s1_advance;

  ocd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: stage 1 moves on when the result register is free or draining
  assign s1_advance   = s1_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.action    <= in_ch.action;
      s1_item.sample    <= in_ch.sample;
      s1_item.power     <= in_ch.power;
      s1_item.pos_width <= in_ch.pos_width;
      s1_item.neg_width <= in_ch.neg_width;
    end
  end

  ocd_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (res_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_reg <= res_comb;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.status      = res_reg.status;
  assign out_ch.rejected    = res_reg.rejected;
  assign out_ch.dac_write   = res_reg.dac_write;
  assign out_ch.drive_level = res_reg.drive_level;
  assign out_ch.gates_on    = res_reg.gates_on;
  assign out_ch.power_error = res_reg.power_error;
  assign out_ch.pulse_valid = res_reg.pulse_valid;
  assign out_ch.pulse_pos   = res_reg.pulse_pos;
  assign out_ch.pulse_neg   = res_reg.pulse_neg;

endmodule
